// ===== rtl/core/cprs_pkg.sv =====
`default_nettype none
package cprs_pkg;
  localparam int unsigned DefMaxRequests = 8;
  localparam int unsigned NumWidth = 4;
  localparam int unsigned CostWidth = 21;
  localparam int unsigned PtWidth = 5;
  localparam int unsigned DistWidth = 16;
  localparam int unsigned CfgIdxWidth = 2;
  localparam logic [CostWidth-1:0] DefaultBound = 21'd1000;
  localparam logic [CfgIdxWidth-1:0] CfgNumRequests = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgCapacity = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgInitialBound = 2'd2;
  localparam logic OpLoad = 1'b0;
  localparam logic OpStart = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic init;       // clear search state
    logic load_cand;  // fetch candidate at current depth, issue matrix read
    logic take;       // push candidate
    logic close_rd;   // read return edge
    logic close_eval; // compare closed route against best
    logic pop;        // retreat one level
    logic undo_rd;    // read edge of point being removed
    logic undo;       // remove top point
    logic skip;       // advance candidate without taking
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic exhausted;  // candidate beyond last point
    logic allowed;    // candidate may be visited
    logic at_last;    // depth equals last
    logic depth_zero; // stack empty
  } sts_t;
endpackage
`default_nettype wire

// ===== rtl/core/cprs_ram.sv =====
`default_nettype none
module cprs_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 289
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/core/cprs_ctrl.sv =====
`default_nettype none
module cprs_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic            hold_i,
  input  wire cprs_pkg::sts_t  sts_i,
  output cprs_pkg::cmd_t       cmd_o,
  output logic                 busy_o,
  output logic                 done_o
);
  import cprs_pkg::*;
  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SFetch = 3'd1;
  localparam logic [2:0] SDec   = 3'd2;
  localparam logic [2:0] SClose = 3'd3;
  localparam logic [2:0] SEval  = 3'd4;
  localparam logic [2:0] SUndo  = 3'd5;
  localparam logic [2:0] SUndo2 = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    done_o = 1'b0;
    unique case (state_q)
      SIdle: if (start_i) begin
        cmd_o.init = 1'b1;
        state_d = SFetch;
      end
      SFetch: begin
        if (sts_i.depth_zero) begin
          // wait here while the previous result is still unread
          if (!hold_i) begin
            done_o = 1'b1;
            state_d = SIdle;
          end
        end else begin
          cmd_o.load_cand = 1'b1;
          state_d = SDec;
        end
      end
      SDec: begin
        if (sts_i.exhausted) begin
          cmd_o.pop = 1'b1;
          state_d = SUndo;
        end else if (!sts_i.allowed) begin
          cmd_o.skip = 1'b1;
          state_d = SFetch;
        end else begin
          cmd_o.take = 1'b1;
          state_d = sts_i.at_last ? SClose : SFetch;
        end
      end
      SClose: begin
        cmd_o.close_rd = 1'b1;
        state_d = SEval;
      end
      SEval: begin
        cmd_o.close_eval = 1'b1;
        state_d = SUndo;
      end
      SUndo: begin
        if (sts_i.depth_zero) state_d = SFetch;
        else begin
          cmd_o.undo_rd = 1'b1;
          state_d = SUndo2;
        end
      end
      SUndo2: begin
        cmd_o.undo = 1'b1;
        state_d = SFetch;
      end
      default: state_d = SIdle;
    endcase
  end

  assign busy_o = (state_q != SIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/cprs_dp.sv =====
`default_nettype none
module cprs_dp #(
  parameter int unsigned MaxRequests = cprs_pkg::DefMaxRequests
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire cprs_pkg::cmd_t                  cmd_i,
  output cprs_pkg::sts_t                       sts_o,
  input  wire logic                            ld_we_i,
  input  wire logic [cprs_pkg::PtWidth-1:0]    ld_from_i,
  input  wire logic [cprs_pkg::PtWidth-1:0]    ld_to_i,
  input  wire logic [cprs_pkg::DistWidth-1:0]  ld_dist_i,
  input  wire logic [cprs_pkg::NumWidth-1:0]   num_requests_i,
  input  wire logic [cprs_pkg::NumWidth-1:0]   capacity_i,
  input  wire logic [cprs_pkg::CostWidth-1:0]  bound_i,
  output logic      [cprs_pkg::CostWidth-1:0]  best_o
);
  import cprs_pkg::*;
  localparam int unsigned NPts = 2 * MaxRequests + 1;
  localparam int unsigned AW = $clog2(NPts * NPts);
  localparam int unsigned DW = $clog2(NPts + 1);
  localparam int unsigned CW = $clog2(NPts + 1); // candidate up to NPts

  logic [NPts-1:0] vis_q;
  logic [PtWidth-1:0] route_q [NPts];
  logic [CW-1:0]  cand_q [NPts];
  logic [DW-1:0]  depth_q;
  logic [NumWidth:0] aboard_q;
  logic [CostWidth-1:0] part_q, best_q;
  logic [CW-1:0] cur_q;

  logic [NumWidth-1:0] n;
  logic [CW-1:0] last;
  assign n = (num_requests_i > NumWidth'(MaxRequests)) ? NumWidth'(MaxRequests)
                                                       : num_requests_i;
  assign last = CW'({n, 1'b0});

  logic [DW-1:0] dm1;
  assign dm1 = depth_q - DW'(1);
  logic [PtWidth-1:0] prev_pt, top_pt;
  assign prev_pt = route_q[dm1[$clog2(NPts)-1:0]];
  assign top_pt = route_q[depth_q[$clog2(NPts)-1:0]];

  // matrix address: a*NPts + b, one multiply by constant
  logic [AW-1:0] raddr, waddr;
  logic [PtWidth-1:0] ra, rb;
  always_comb begin
    ra = prev_pt;
    rb = cur_q[PtWidth-1:0];
    if (cmd_i.load_cand) rb = cand_q[depth_q[$clog2(NPts)-1:0]][PtWidth-1:0];
    if (cmd_i.close_rd) begin ra = cur_q[PtWidth-1:0]; rb = '0; end
    if (cmd_i.undo_rd) rb = top_pt;
  end
  assign raddr = AW'(ra * NPts + rb);
  assign waddr = AW'(ld_from_i * NPts + ld_to_i);
  logic wr_ok;
  assign wr_ok = ld_we_i && (ld_from_i < PtWidth'(NPts)) && (ld_to_i < PtWidth'(NPts));

  logic [DistWidth-1:0] rdata;
  cprs_ram #(.Width(DistWidth), .Depth(NPts * NPts)) u_mat (
    .clk_i, .we_i(wr_ok), .waddr_i(waddr), .wdata_i(ld_dist_i),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic is_pick;
  assign is_pick = ({1'b0, cur_q} <= {1'b0, CW'(n)});
  logic [CW-1:0] partner;
  assign partner = cur_q - CW'(n);
  always_comb begin
    sts_o.exhausted = cur_q > last;
    sts_o.allowed = 1'b0;
    if (cur_q != '0 && !vis_q[cur_q[$clog2(NPts)-1:0]]) begin
      if (is_pick) sts_o.allowed = ({1'b0, aboard_q} < {1'b0, 1'b0, capacity_i});
      else sts_o.allowed = vis_q[partner[$clog2(NPts)-1:0]];
    end
    sts_o.at_last = (CW'(depth_q) == last);
    sts_o.depth_zero = (depth_q == '0);
  end

  logic top_pick;
  assign top_pick = ({1'b0, top_pt} <= {1'b0, PtWidth'(n)});
  logic [CostWidth-1:0] total;
  assign total = part_q + CostWidth'(rdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vis_q <= '0; depth_q <= '0; aboard_q <= '0; part_q <= '0;
      best_q <= DefaultBound; cur_q <= '0;
      for (int i = 0; i < NPts; i++) begin route_q[i] <= '0; cand_q[i] <= '0; end
    end else begin
      if (cmd_i.init) begin
        vis_q <= '0; depth_q <= DW'(1); aboard_q <= '0; part_q <= '0;
        best_q <= bound_i;
        for (int i = 0; i < NPts; i++) begin
          route_q[i] <= '0;
          cand_q[i] <= (i == 1) ? CW'(1) : '0;
        end
      end
      if (cmd_i.load_cand) cur_q <= cand_q[depth_q[$clog2(NPts)-1:0]];
      if (cmd_i.skip || cmd_i.take)
        cand_q[depth_q[$clog2(NPts)-1:0]] <= cur_q + CW'(1);
      if (cmd_i.take) begin
        route_q[depth_q[$clog2(NPts)-1:0]] <= cur_q[PtWidth-1:0];
        vis_q[cur_q[$clog2(NPts)-1:0]] <= 1'b1;
        aboard_q <= is_pick ? aboard_q + 1'b1 : aboard_q - 1'b1;
        part_q <= part_q + CostWidth'(rdata);
        if (!sts_o.at_last) begin
          depth_q <= depth_q + DW'(1);
          cand_q[depth_q[$clog2(NPts)-1:0] + 1'b1] <= CW'(1);
        end
      end
      if (cmd_i.close_eval && total < best_q) best_q <= total;
      if (cmd_i.pop) depth_q <= dm1;
      if (cmd_i.undo) begin
        vis_q[top_pt[$clog2(NPts)-1:0]] <= 1'b0;
        aboard_q <= top_pick ? aboard_q - 1'b1 : aboard_q + 1'b1;
        part_q <= part_q - CostWidth'(rdata);
      end
    end
  end
  assign best_o = best_q;
endmodule
`default_nettype wire

// ===== rtl/core/capacitated_pickup_delivery_route_search.sv =====
// Timing: a load item writes one matrix entry; a start item runs the full depth-first
//   search, trying candidates through one matrix read port; the search waits to finish
//   while the previous result is unread, then its result is registered.
// Throughput: load items 1 per cycle while no search runs; one search at a time.
// Reset (async, active low): config to n=1, capacity=1, bound=1000; no result pending.
`default_nettype none
module capacitated_pickup_delivery_route_search #(
  parameter int unsigned MaxRequests = cprs_pkg::DefMaxRequests
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // from_point[4:0], to_point[9:5], distance[25:10], zero fill
  input  wire logic [31:0]                         s_axis_tdata,
  // op[0]
  input  wire logic [0:0]                          s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // best_cost[20:0], found[21], zero fill
  output logic [23:0]                              m_axis_tdata,
  input  wire logic                                cfg_we_i,
  input  wire logic [cprs_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  wire logic [cprs_pkg::CostWidth-1:0]      cfg_data_i
);
  import cprs_pkg::*;
  logic [NumWidth-1:0] nreq_q, cap_q;
  logic [CostWidth-1:0] bound_q, best;
  logic busy, done, start, ld, hold;
  logic ovalid_q;
  logic [CostWidth:0] out_q;
  cmd_t cmd;
  sts_t sts;

  assign s_axis_tready = !busy;
  assign ld = s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == OpLoad);
  assign start = s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == OpStart);
  // result register full and not draining this cycle
  assign hold = ovalid_q && !m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nreq_q <= NumWidth'(1); cap_q <= NumWidth'(1); bound_q <= DefaultBound;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgNumRequests:  nreq_q <= cfg_data_i[NumWidth-1:0];
          CfgCapacity:     cap_q <= cfg_data_i[NumWidth-1:0];
          CfgInitialBound: bound_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (done) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) if (done) out_q <= {best < bound_q, best};

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = {2'b00, out_q};

  cprs_ctrl u_ctrl (.clk_i, .rst_ni, .start_i(start), .hold_i(hold), .sts_i(sts),
                    .cmd_o(cmd), .busy_o(busy), .done_o(done));
  cprs_dp #(.MaxRequests(MaxRequests)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .ld_we_i(ld),
    .ld_from_i(s_axis_tdata[4:0]), .ld_to_i(s_axis_tdata[9:5]),
    .ld_dist_i(s_axis_tdata[25:10]), .num_requests_i(nreq_q), .capacity_i(cap_q),
    .bound_i(bound_q), .best_o(best)
  );
endmodule
`default_nettype wire

// ===== rtl/core/cprs_checker.sv =====
`default_nettype none
module cprs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [0:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result dropped or changed while waiting");
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !s_axis_tuser[0] && !m_axis_tvalid)
      |=> !m_axis_tvalid) else $error("result from load item");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser[0]) |=> !s_axis_tready)
    else $error("ready during search");
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23:22] == 2'b00) else $error("pad nonzero");
endmodule
bind capacitated_pickup_delivery_route_search cprs_checker u_chk (.*);
`default_nettype wire
